[sv/lrukv_pkg.sv]
// ---------------------------------------------------------------------------
// lrukv_pkg: shared types and constants
// Entry count, field widths, request codes and the transaction structs
// passed between the top level and the entry store.
// ---------------------------------------------------------------------------
package lrukv_pkg;

    localparam int ENTRIES = 16;
    localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
    localparam logic              REQ_GET        = 1'b0;
    localparam logic              REQ_PUT        = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE     = '1;
    localparam logic [DATA_W-1:0] PUT_VALUE      = '0;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } t_rsp;

endpackage

[sv/lrukv_store.sv]
// ---------------------------------------------------------------------------
// lrukv_store: associative entry store with recency ages
// Compares the key against all valid entries in parallel, forms the
// response and updates keys, values, ages and the fill count.
// ---------------------------------------------------------------------------
module lrukv_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  lrukv_pkg::t_req           i_req,
    input  logic [lrukv_pkg::CAP_W-1:0] i_capacity,
    output lrukv_pkg::t_rsp           o_rsp
);
    import lrukv_pkg::*;

    logic [ENTRIES-1:0]       r_valid;
    logic [DATA_W-1:0]        r_key   [ENTRIES];
    logic [DATA_W-1:0]        r_value [ENTRIES];
    logic [AGE_W-1:0]         r_age   [ENTRIES];
    logic [CNT_W-1:0]         r_count;

    logic [ENTRIES-1:0]       hit_mask;
    logic [ENTRIES-1:0]       victim_mask;
    logic [ENTRIES-1:0]       free_mask;
    logic [ENTRIES-1:0]       sel_mask;
    logic [DATA_W-1:0]        hit_value;
    logic [AGE_W-1:0]         hit_age;
    logic [CNT_W-1:0]         ref_age;
    logic [CNT_W-1:0]         n_count;
    logic                     hit;
    logic                     is_put;
    logic                     full;
    logic                     do_evict;
    logic                     do_insert;
    logic                     touch;

    always_comb begin
        hit_value = '0;
        hit_age   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_mask[i]    = r_valid[i] && (r_key[i] == i_req.key);
            victim_mask[i] = r_valid[i] && (CNT_W'(r_age[i]) == r_count - CNT_W'(1));
            if (hit_mask[i]) begin
                hit_value = hit_value | r_value[i];
                hit_age   = hit_age | r_age[i];
            end
        end
    end

    assign free_mask = ~r_valid & (r_valid + ENTRIES'(1));
    assign hit       = |hit_mask;
    assign is_put    = (i_req.req_type == REQ_PUT);
    assign full      = (r_count != '0)
                       && ((CMP_W'(r_count) >= CMP_W'(i_capacity))
                           || (r_count == CNT_W'(ENTRIES)));
    assign do_evict  = is_put && !hit && full;
    assign do_insert = is_put && !hit && !full;
    assign touch     = hit || is_put;
    assign n_count   = r_count + CNT_W'(1);

    always_comb begin
        priority if (hit) begin
            sel_mask = hit_mask;
            ref_age  = CNT_W'(hit_age);
        end else if (do_evict) begin
            sel_mask = victim_mask;
            ref_age  = r_count - CNT_W'(1);
        end else begin
            sel_mask = free_mask;
            ref_age  = r_count;
        end
    end

    always_comb begin
        o_rsp.hit     = hit;
        o_rsp.evicted = do_evict;
        priority if (is_put) begin
            o_rsp.read_value = PUT_VALUE;
        end else if (hit) begin
            o_rsp.read_value = hit_value;
        end else begin
            o_rsp.read_value = MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_fire && touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sel_mask[i]) begin
                    r_age[i] <= '0;
                end else if (r_valid[i] && (CNT_W'(r_age[i]) < ref_age)) begin
                    r_age[i] <= r_age[i] + AGE_W'(1);
                end
            end
            if (do_insert) begin
                r_valid <= r_valid | sel_mask;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sel_mask[i]) begin
                    r_value[i] <= i_req.value;
                    if (!hit) begin
                        r_key[i] <= i_req.key;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("fill count differs from number of valid entries");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_mask))
        else $error("key present in more than one entry");

    a_victim_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_evict |-> $onehot(victim_mask))
        else $error("no unique least recent entry on eviction");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_insert |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not advance the fill count");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && do_insert |-> $onehot(free_mask))
        else $error("insert with no free entry");
`endif

endmodule

[sv/lru_key_value_cache_unit.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit: key-value cache with LRU replacement
// Registers each request, resolves it against the entry store and holds
// responses in a two-deep output buffer.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_req_type, i_key, i_value
//   response  out        o_valid / i_stall  o_hit, o_read_value, o_evicted
//   config    in         i_cfg_wr_en        i_cfg_wr_data (capacity)
//
// One transaction per cycle sustained while i_stall is low; a response
// passes through the request register and the response register around
// the parallel key compare and age update; a request waits in the request
// register while the skid entry is full.
// Reset empties the store, restores capacity 16 and clears both buffers.
// A stalled response is held; a second response waits in the skid entry,
// and requests stall only when both response slots are taken.
// ---------------------------------------------------------------------------
module lru_key_value_cache_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_key,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic signed [lrukv_pkg::DATA_W-1:0] o_read_value,
    output logic                                o_evicted,
    input  logic                                i_cfg_wr_en,
    input  logic [lrukv_pkg::CAP_W-1:0]         i_cfg_wr_data
);
    import lrukv_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             r_req_valid;
    t_req             r_req;
    logic             r_out_valid;
    t_rsp             r_out;
    logic             r_skid_valid;
    t_rsp             r_skid;
    t_rsp             rsp;
    t_req             n_req;
    logic             fire;
    logic             in_accept;
    logic             out_take;

    assign fire      = r_req_valid && !r_skid_valid;
    assign o_stall   = r_req_valid && r_skid_valid;
    assign in_accept = i_valid && !o_stall;
    assign out_take  = r_out_valid && !i_stall;

    assign n_req.req_type = i_req_type;
    assign n_req.key      = i_key;
    assign n_req.value    = i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (in_accept) begin
            r_req_valid <= 1'b1;
        end else if (fire) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= n_req;
        end
    end

    lrukv_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req      (r_req),
        .i_capacity (r_capacity),
        .o_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= fire;
            end
        end else if (fire) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (fire) begin
                r_out <= rsp;
            end
        end else if (fire) begin
            if (r_out_valid) begin
                r_skid <= rsp;
            end else begin
                r_out <= rsp;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out.hit;
    assign o_read_value = r_out.read_value;
    assign o_evicted    = r_out.evicted;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_no_fire_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !fire)
        else $error("response produced with both slots full");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("stalled response dropped");
`endif

endmodule
